// ----- hdl/msd_pkg.sv -----
`default_nettype none
package msd_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  localparam int TIME_W = 32;
  localparam int POS_W  = 24;
  localparam int MAG_W  = POS_W + 1;
  localparam int SQ_W   = 2 * POS_W + 1;
  localparam int SUM_W  = SQ_W + $clog2(3 * MAX_PARTICLES);
  localparam int MEAN_W = 50;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos3_t;

  typedef struct packed {
    logic [TIME_W-1:0]       sample_time;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    last;
  } msd_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] delta_time;
    logic [MEAN_W-1:0] mean_sq_disp;
    logic              count_mismatch;
  } msd_out_t;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

endpackage
`default_nettype wire

// ----- hdl/msd_ram.sv -----
`default_nettype none
module msd_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                              wdata,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- hdl/msd_div.sv -----
`default_nettype none
module msd_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [msd_pkg::SUM_W-1:0] dividend,
  input  wire logic [msd_pkg::CNT_W-1:0] divisor,
  input  wire logic                      ack,
  output logic                           done,
  output logic [msd_pkg::MEAN_W-1:0]     quotient
);
  import msd_pkg::*;

  div_state_t        state;
  logic [SUM_W-1:0]  num;
  logic [CNT_W-1:0]  den;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;
  logic [CNT_W:0]    rem_sh;
  logic              q_bit;
  logic [CNT_W:0]    rem_sub;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    rem_sh  = {rem, num[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, den});
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      case (state)
        DIV_IDLE: begin
          if (start) begin
            state <= DIV_RUN;
          end
        end
        DIV_RUN: begin
          if (step == '0) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (ack) begin
            state <= DIV_IDLE;
          end
        end
        default: state <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      step <= STEP_W'(SUM_W - 1);
    end else if (state == DIV_RUN) begin
      num  <= {num[SUM_W-2:0], q_bit};
      rem  <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step <= step - STEP_W'(1);
    end
  end

  // a zero divisor means nothing was summed
  always_comb begin
    done = (state == DIV_DONE);
    if (den == '0) begin
      quotient = '0;
    end else if (|num[SUM_W-1:MEAN_W]) begin
      quotient = MEAN_MAX;
    end else begin
      quotient = num[MEAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mean_squared_displacement_top.sv -----
// Mean squared displacement against a stored reference snapshot. Particles
// stream in one per transfer, a snapshot closed by last; the first accepted
// snapshot is kept in a 1024-entry position memory, and each later accepted
// snapshot gives one result on its last particle. Within a snapshot the block
// takes one particle per clock (memory read, squaring and accumulation are
// pipelined). After the last particle of a scored snapshot the input holds
// off while the result passes 2 pipeline stages, the divider load, 61 serial
// divide steps forming the mean and the move to the output register, and
// until the previous result has been taken.
`default_nettype none
module mean_squared_displacement_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire msd_pkg::msd_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output msd_pkg::msd_out_t      out_data
);
  import msd_pkg::*;

  logic [TIME_W-1:0] measure_interval;
  logic [TIME_W-1:0] reference_time;
  logic [CNT_W-1:0]  reference_count;
  logic              have_reference;
  logic [TIME_W-1:0] last_accept_time;
  logic              have_accepted;
  logic              frame_start;
  logic              frame_taken;
  logic [CNT_W-1:0]  particle_index;
  logic              overflow_seen;
  logic [TIME_W-1:0] frame_time;
  logic              busy;

  logic [TIME_W-1:0] res_delta;
  logic              res_mismatch;
  logic [CNT_W-1:0]  res_used;

  logic              in_fire;
  logic              take;
  logic              cur_taken;
  logic [CNT_W-1:0]  cur_idx;
  logic              cur_ovf;
  logic [TIME_W-1:0] cur_ftime;
  logic              in_range;
  logic [CNT_W-1:0]  idx_next;
  logic              ovf_next;
  logic              use_ref;
  logic              fin;
  logic [CNT_W-1:0]  used;
  logic              ram_we;
  pos3_t             ram_wdata;
  pos3_t             ram_rdata;

  logic              s1_valid;
  logic              s1_first;
  logic              s1_add;
  logic              s1_fin;
  pos3_t             s1_pos;
  logic              s2_valid;
  logic              s2_first;
  logic              s2_add;
  logic              s2_fin;
  logic [SQ_W-1:0]   s2_sq [3];
  logic [SQ_W-1:0]   sq_next [3];
  logic [SUM_W-1:0]  sq_sum;
  logic [SUM_W-1:0]  sq_sum_next;

  logic              div_done;
  logic              div_ack;
  logic [MEAN_W-1:0] div_q;
  logic              load;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      measure_interval <= '0;
    end else if (cfg_we) begin
      measure_interval <= cfg_wdata;
    end
  end

  // per-particle bookkeeping, done at the input transfer
  always_comb begin
    take = !have_accepted ||
           (in_data.sample_time > last_accept_time &&
            (in_data.sample_time - last_accept_time) > measure_interval);
    cur_taken = frame_start ? take : frame_taken;
    cur_idx   = frame_start ? '0 : particle_index;
    cur_ovf   = frame_start ? 1'b0 : overflow_seen;
    cur_ftime = frame_start ? in_data.sample_time : frame_time;
    in_range  = cur_idx < CNT_W'(MAX_PARTICLES);
    idx_next  = in_range ? cur_idx + CNT_W'(1) : cur_idx;
    ovf_next  = cur_ovf || !in_range;
    use_ref   = cur_taken && in_range && have_reference && (cur_idx < reference_count);
    fin       = cur_taken && in_data.last && have_reference;
    used      = (idx_next < reference_count) ? idx_next : reference_count;
    ram_we    = in_fire && cur_taken && in_range && !have_reference;
    ram_wdata = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z};
  end

  msd_ram #(
    .WIDTH($bits(pos3_t)),
    .DEPTH(MAX_PARTICLES)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (cur_idx[IDX_W-1:0]),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_time   <= '0;
      reference_count  <= '0;
      have_reference   <= 1'b0;
      last_accept_time <= '0;
      have_accepted    <= 1'b0;
      frame_start      <= 1'b1;
      frame_taken      <= 1'b0;
      particle_index   <= '0;
      overflow_seen    <= 1'b0;
      frame_time       <= '0;
      busy             <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_start    <= in_data.last;
        frame_taken    <= in_data.last ? 1'b0 : cur_taken;
        particle_index <= idx_next;
        overflow_seen  <= ovf_next;
        frame_time     <= cur_ftime;
        if (frame_start && take) begin
          have_accepted    <= 1'b1;
          last_accept_time <= in_data.sample_time;
        end
        if (cur_taken && in_data.last && !have_reference) begin
          have_reference  <= 1'b1;
          reference_count <= idx_next;
          reference_time  <= cur_ftime;
        end
      end
      if (in_fire && fin) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && fin) begin
      res_delta    <= cur_ftime - reference_time;
      res_mismatch <= ovf_next || (idx_next != reference_count);
      res_used     <= used;
    end
  end

  // stage 1: reference entry comes back from memory
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    s1_first <= frame_start;
    s1_add   <= use_ref;
    s1_fin   <= fin;
    s1_pos   <= ram_wdata;
  end

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [POS_W-1:0] a,
                                             input logic signed [POS_W-1:0] b);
    logic signed [MAG_W-1:0] d;
    logic [MAG_W-1:0]        m;
    logic [2*MAG_W-1:0]      p;
    d = MAG_W'(a) - MAG_W'(b);
    m = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
    p = m * m;
    return p[SQ_W-1:0];
  endfunction

  always_comb begin
    sq_next[0] = sq_diff(s1_pos.x, ram_rdata.x);
    sq_next[1] = sq_diff(s1_pos.y, ram_rdata.y);
    sq_next[2] = sq_diff(s1_pos.z, ram_rdata.z);
  end

  // stage 2: squared displacements registered
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_first <= s1_first;
    s2_add   <= s1_add;
    s2_fin   <= s1_fin;
    s2_sq    <= sq_next;
  end

  // sum cannot exceed SUM_W bits for MAX_PARTICLES particles
  always_comb begin
    sq_sum_next = s2_first ? '0 : sq_sum;
    if (s2_add) begin
      sq_sum_next = sq_sum_next + SUM_W'(s2_sq[0]) + SUM_W'(s2_sq[1]) + SUM_W'(s2_sq[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_sum <= '0;
    end else if (s2_valid) begin
      sq_sum <= sq_sum_next;
    end
  end

  msd_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (s2_valid && s2_fin),
    .dividend(sq_sum_next),
    .divisor (res_used),
    .ack     (div_ack),
    .done    (div_done),
    .quotient(div_q)
  );

  assign load    = div_done && (!out_valid || out_ready);
  assign div_ack = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.delta_time     <= res_delta;
      out_data.mean_sq_disp   <= div_q;
      out_data.count_mismatch <= res_mismatch;
    end
  end

endmodule
`default_nettype wire
